>>> src/closest_point_on_triangle_defines.svh
// Assertion macros for the closest-point RTL.
// Depends on nothing; included by cpt_blend, the module that carries checks.
`ifndef CLOSEST_POINT_ON_TRIANGLE_DEFINES_SVH
`define CLOSEST_POINT_ON_TRIANGLE_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define CPT_ASSERT_IMP(name, clk_i, rst_ni, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("closest point: same-cycle check failed");

// Next-cycle implication, quiet during reset.
`define CPT_ASSERT_NXT(name, clk_i, rst_ni, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("closest point: next-cycle check failed");

`endif

>>> src/cpt_pkg.sv
// Shared types and codes for the closest-point-on-triangle pipeline.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package cpt_pkg;

  localparam int FIELD_W    = 16;
  localparam int IN_FIELDS  = 12;
  localparam int IN_DATA_W  = FIELD_W * IN_FIELDS;
  localparam int OUT_DATA_W = 3 * FIELD_W;
  localparam int OUT_USER_W = 4;

  // Region numbering
  localparam logic [2:0] REG_INTERIOR = 3'd0;
  localparam logic [2:0] REG_EDGE_ST  = 3'd1;  // s + t = 1
  localparam logic [2:0] REG_EDGE_S0  = 3'd2;  // s = 0
  localparam logic [2:0] REG_EDGE_T0  = 3'd3;  // t = 0
  localparam logic [2:0] REG_VERT_S   = 3'd4;
  localparam logic [2:0] REG_VERT_0   = 3'd5;
  localparam logic [2:0] REG_VERT_T   = 3'd6;

  // Divider lanes
  localparam int LANE_S = 0;
  localparam int LANE_T = 1;

  // Quotient classes decided before the iterations
  localparam logic [1:0] CLS_ZERO = 2'd0;
  localparam logic [1:0] CLS_ONE  = 2'd1;
  localparam logic [1:0] CLS_DIV  = 2'd2;

  typedef struct packed {
    logic [2:0] region;
    logic [1:0] en;      // lane needs a quotient
    logic       s_comp;  // s = 1 - t
    logic       t_comp;  // t = 1 - s
    logic       degen;
  } cpt_ctrl_t;

endpackage

`default_nettype wire

>>> src/cpt_setup.sv
// Front of the pipeline: edges, dot products, determinants and region sort.
// Depends on cpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpt_setup #(
  parameter int COORD_WIDTH = 16,
  localparam int W      = COORD_WIDTH,
  localparam int E      = W + 1,
  localparam int DOTW   = 2 * E + 2,
  localparam int PW     = 2 * DOTW,
  localparam int DW     = PW + 2,
  localparam int SIDE_W = 3 * (W + 2 * E)
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire  [cpt_pkg::IN_DATA_W-1:0]  in_data,
  output logic                           out_valid,
  input  wire                            out_ready,
  output cpt_pkg::cpt_ctrl_t             out_ctrl,
  output logic signed [DW-1:0]           out_num [2],
  output logic signed [DW-1:0]           out_den [2],
  output logic [SIDE_W-1:0]              out_side
);

  localparam int N = 6;
  localparam int IA = 0, IB = 1, IC = 2, ID = 3, IE = 4;

  logic [N-1:0] v_r;
  logic [N:0]   rdy;
  logic [N-1:0] vin;

  always_comb begin
    rdy[N] = out_ready;
    for (int s = N - 1; s >= 0; s--) rdy[s] = !v_r[s] || rdy[s+1];
  end

  assign vin = {v_r[N-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < N; s++) if (rdy[s]) v_r[s] <= vin[s];
    end
  end

  // coordinate extraction
  logic signed [W-1:0] crd [cpt_pkg::IN_FIELDS];
  for (genvar f = 0; f < cpt_pkg::IN_FIELDS; f++) begin : g_crd
    if (W <= cpt_pkg::FIELD_W) begin : g_narrow
      assign crd[f] = in_data[f*cpt_pkg::FIELD_W +: W];
    end else begin : g_wide
      assign crd[f] = W'(in_data[f*cpt_pkg::FIELD_W +: cpt_pkg::FIELD_W]);
    end
  end

  logic signed [E-1:0] e0c [3], e1c [3], v0c [3];
  logic [SIDE_W-1:0]   side_in;

  always_comb begin
    side_in = '0;
    for (int i = 0; i < 3; i++) begin
      e0c[i] = E'(crd[3+i]) - E'(crd[i]);
      e1c[i] = E'(crd[6+i]) - E'(crd[i]);
      v0c[i] = E'(crd[i]) - E'(crd[9+i]);
      side_in[i*(W+2*E) +: W]       = crd[i];
      side_in[i*(W+2*E)+W +: E]     = e0c[i];
      side_in[i*(W+2*E)+W+E +: E]   = e1c[i];
    end
  end

  logic signed [E-1:0]    e0_r [3], e1_r [3], v0_r [3];
  logic signed [2*E-1:0]  pr_r [15];
  logic signed [DOTW-1:0] dot_r [5];
  logic signed [DOTW-1:0] dot4_r [5];
  logic signed [PW-1:0]   m_r [6];
  logic signed [DW-1:0]   det_r, sn_r, tn_r, den2_r, dce_r, dad_r, negd_r, nege_r;
  logic signed [DW-1:0]   a5_r, c5_r;
  logic                   dneg_r;
  logic [SIDE_W-1:0]      side_r [N];
  cpt_pkg::cpt_ctrl_t     ctrl_r;
  logic signed [DW-1:0]   num_r [2], den_r [2];

  // region sort
  cpt_pkg::cpt_ctrl_t     ctrl_nxt;
  logic signed [DW-1:0]   num_nxt [2], den_nxt [2];
  logic signed [DW-1:0]   sum_st;

  always_comb begin
    sum_st   = sn_r + tn_r;
    ctrl_nxt = '0;
    for (int l = 0; l < 2; l++) begin
      num_nxt[l] = '0;
      den_nxt[l] = '0;
    end
    if (sum_st < det_r) begin
      if (sn_r[DW-1]) begin
        if (tn_r[DW-1]) begin
          ctrl_nxt.region = cpt_pkg::REG_VERT_0;
          if (dneg_r) begin
            ctrl_nxt.en[cpt_pkg::LANE_S] = 1'b1;
            num_nxt[cpt_pkg::LANE_S]     = negd_r;
            den_nxt[cpt_pkg::LANE_S]     = a5_r;
          end else begin
            ctrl_nxt.en[cpt_pkg::LANE_T] = 1'b1;
            num_nxt[cpt_pkg::LANE_T]     = nege_r;
            den_nxt[cpt_pkg::LANE_T]     = c5_r;
          end
        end else begin
          ctrl_nxt.region              = cpt_pkg::REG_EDGE_S0;
          ctrl_nxt.en[cpt_pkg::LANE_T] = 1'b1;
          num_nxt[cpt_pkg::LANE_T]     = nege_r;
          den_nxt[cpt_pkg::LANE_T]     = c5_r;
        end
      end else if (tn_r[DW-1]) begin
        ctrl_nxt.region              = cpt_pkg::REG_EDGE_T0;
        ctrl_nxt.en[cpt_pkg::LANE_S] = 1'b1;
        num_nxt[cpt_pkg::LANE_S]     = negd_r;
        den_nxt[cpt_pkg::LANE_S]     = a5_r;
      end else begin
        ctrl_nxt.region = cpt_pkg::REG_INTERIOR;
        ctrl_nxt.en     = 2'b11;
        num_nxt[cpt_pkg::LANE_S] = sn_r;
        den_nxt[cpt_pkg::LANE_S] = det_r;
        num_nxt[cpt_pkg::LANE_T] = tn_r;
        den_nxt[cpt_pkg::LANE_T] = det_r;
      end
    end else if (sn_r[DW-1]) begin
      ctrl_nxt.region = cpt_pkg::REG_VERT_S;
      if (dce_r > 0) begin
        ctrl_nxt.en[cpt_pkg::LANE_S] = 1'b1;
        ctrl_nxt.t_comp              = 1'b1;
        num_nxt[cpt_pkg::LANE_S]     = dce_r;
        den_nxt[cpt_pkg::LANE_S]     = den2_r;
      end else begin
        ctrl_nxt.en[cpt_pkg::LANE_T] = 1'b1;
        num_nxt[cpt_pkg::LANE_T]     = nege_r;
        den_nxt[cpt_pkg::LANE_T]     = c5_r;
      end
    end else if (tn_r[DW-1]) begin
      ctrl_nxt.region = cpt_pkg::REG_VERT_T;
      if (dad_r > 0) begin
        ctrl_nxt.en[cpt_pkg::LANE_T] = 1'b1;
        ctrl_nxt.s_comp              = 1'b1;
        num_nxt[cpt_pkg::LANE_T]     = dad_r;
        den_nxt[cpt_pkg::LANE_T]     = den2_r;
      end else begin
        ctrl_nxt.en[cpt_pkg::LANE_S] = 1'b1;
        num_nxt[cpt_pkg::LANE_S]     = negd_r;
        den_nxt[cpt_pkg::LANE_S]     = a5_r;
      end
    end else begin
      ctrl_nxt.region              = cpt_pkg::REG_EDGE_ST;
      ctrl_nxt.en[cpt_pkg::LANE_S] = 1'b1;
      ctrl_nxt.t_comp              = 1'b1;
      num_nxt[cpt_pkg::LANE_S]     = dce_r;
      den_nxt[cpt_pkg::LANE_S]     = den2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int i = 0; i < 3; i++) begin
        e0_r[i] <= e0c[i];
        e1_r[i] <= e1c[i];
        v0_r[i] <= v0c[i];
      end
      side_r[0] <= side_in;
    end
    if (rdy[1]) begin
      for (int i = 0; i < 3; i++) begin
        pr_r[i]    <= (2*E)'(e0_r[i]) * (2*E)'(e0_r[i]);
        pr_r[3+i]  <= (2*E)'(e0_r[i]) * (2*E)'(e1_r[i]);
        pr_r[6+i]  <= (2*E)'(e1_r[i]) * (2*E)'(e1_r[i]);
        pr_r[9+i]  <= (2*E)'(e0_r[i]) * (2*E)'(v0_r[i]);
        pr_r[12+i] <= (2*E)'(e1_r[i]) * (2*E)'(v0_r[i]);
      end
    end
    if (rdy[2]) begin
      for (int k = 0; k < 5; k++)
        dot_r[k] <= DOTW'(pr_r[3*k]) + DOTW'(pr_r[3*k+1]) + DOTW'(pr_r[3*k+2]);
    end
    if (rdy[3]) begin
      m_r[0] <= PW'(dot_r[IA]) * PW'(dot_r[IC]);
      m_r[1] <= PW'(dot_r[IB]) * PW'(dot_r[IB]);
      m_r[2] <= PW'(dot_r[IB]) * PW'(dot_r[IE]);
      m_r[3] <= PW'(dot_r[IC]) * PW'(dot_r[ID]);
      m_r[4] <= PW'(dot_r[IB]) * PW'(dot_r[ID]);
      m_r[5] <= PW'(dot_r[IA]) * PW'(dot_r[IE]);
      dot4_r <= dot_r;
    end
    if (rdy[4]) begin
      det_r  <= DW'(m_r[0]) - DW'(m_r[1]);
      sn_r   <= DW'(m_r[2]) - DW'(m_r[3]);
      tn_r   <= DW'(m_r[4]) - DW'(m_r[5]);
      den2_r <= DW'(dot4_r[IA]) - DW'(dot4_r[IB]) - DW'(dot4_r[IB]) + DW'(dot4_r[IC]);
      dce_r  <= DW'(dot4_r[IC]) + DW'(dot4_r[IE]) - DW'(dot4_r[IB]) - DW'(dot4_r[ID]);
      dad_r  <= DW'(dot4_r[IA]) + DW'(dot4_r[ID]) - DW'(dot4_r[IB]) - DW'(dot4_r[IE]);
      negd_r <= -DW'(dot4_r[ID]);
      nege_r <= -DW'(dot4_r[IE]);
      a5_r   <= DW'(dot4_r[IA]);
      c5_r   <= DW'(dot4_r[IC]);
      dneg_r <= dot4_r[ID][DOTW-1];
    end
    if (rdy[5]) begin
      ctrl_r <= ctrl_nxt;
      num_r  <= num_nxt;
      den_r  <= den_nxt;
    end
    for (int s = 1; s < N; s++) if (rdy[s]) side_r[s] <= side_r[s-1];
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[N-1];
  assign out_ctrl  = ctrl_r;
  assign out_num   = num_r;
  assign out_den   = den_r;
  assign out_side  = side_r[N-1];

endmodule

`default_nettype wire

>>> src/cpt_div.sv
// Two-lane pipelined restoring divider for the barycentric weights.
// One quotient bit per stage; depends on cpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpt_div #(
  parameter int COORD_WIDTH      = 16,
  parameter int WEIGHT_FRAC_BITS = 16,
  localparam int W      = COORD_WIDTH,
  localparam int F      = WEIGHT_FRAC_BITS,
  localparam int E      = W + 1,
  localparam int DW     = 4 * E + 6,
  localparam int SIDE_W = 3 * (W + 2 * E)
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  cpt_pkg::cpt_ctrl_t     in_ctrl,
  input  wire signed [DW-1:0]    in_num [2],
  input  wire signed [DW-1:0]    in_den [2],
  input  wire [SIDE_W-1:0]       in_side,
  output logic                   out_valid,
  input  wire                    out_ready,
  output cpt_pkg::cpt_ctrl_t     out_ctrl,
  output logic [F:0]             out_q [2],
  output logic [1:0]             out_cls [2],
  output logic [SIDE_W-1:0]      out_side
);

  localparam int N = F + 2;

  logic [N-1:0] v_r;
  logic [N:0]   rdy;
  logic [N-1:0] vin;

  always_comb begin
    rdy[N] = out_ready;
    for (int s = N - 1; s >= 0; s--) rdy[s] = !v_r[s] || rdy[s+1];
  end

  assign vin = {v_r[N-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < N; s++) if (rdy[s]) v_r[s] <= vin[s];
    end
  end

  logic [DW-1:0]       r_r   [N][2];
  logic [DW-1:0]       den_r [N][2];
  logic [F:0]          q_r   [N][2];
  logic [1:0]          cls_r [N][2];
  cpt_pkg::cpt_ctrl_t  ctrl_r [N];
  logic [SIDE_W-1:0]   side_r [N];

  // classify: disabled lane, zero divisor, non-positive numerator, saturated
  cpt_pkg::cpt_ctrl_t ctrl_nxt;
  logic [1:0]         cls_nxt [2];

  always_comb begin
    ctrl_nxt = in_ctrl;
    for (int l = 0; l < 2; l++) begin
      if (!in_ctrl.en[l]) begin
        cls_nxt[l] = cpt_pkg::CLS_ZERO;
      end else if (in_den[l] == '0) begin
        cls_nxt[l]     = cpt_pkg::CLS_ZERO;
        ctrl_nxt.degen = 1'b1;
      end else if (in_num[l] <= 0) begin
        cls_nxt[l] = cpt_pkg::CLS_ZERO;
      end else if (!(in_num[l] < in_den[l])) begin
        cls_nxt[l] = cpt_pkg::CLS_ONE;
      end else begin
        cls_nxt[l] = cpt_pkg::CLS_DIV;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int l = 0; l < 2; l++) begin
        r_r[0][l]   <= in_num[l];
        den_r[0][l] <= in_den[l];
        q_r[0][l]   <= '0;
        cls_r[0][l] <= cls_nxt[l];
      end
      ctrl_r[0] <= ctrl_nxt;
      side_r[0] <= in_side;
    end
  end

  for (genvar k = 1; k < N; k++) begin : g_iter
    logic [DW:0] sh [2];
    logic [DW:0] df [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        sh[l] = {r_r[k-1][l], 1'b0};
        df[l] = sh[l] - {1'b0, den_r[k-1][l]};
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        for (int l = 0; l < 2; l++) begin
          r_r[k][l]   <= df[l][DW] ? sh[l][DW-1:0] : df[l][DW-1:0];
          q_r[k][l]   <= {q_r[k-1][l][F-1:0], ~df[l][DW]};
          den_r[k][l] <= den_r[k-1][l];
          cls_r[k][l] <= cls_r[k-1][l];
        end
        ctrl_r[k] <= ctrl_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[N-1];
  assign out_ctrl  = ctrl_r[N-1];
  assign out_q     = q_r[N-1];
  assign out_cls   = cls_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

`default_nettype wire

>>> src/cpt_blend.sv
// Back of the pipeline: weight rounding, edge blend, rounding and saturation.
// Depends on cpt_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "closest_point_on_triangle_defines.svh"

module cpt_blend #(
  parameter int COORD_WIDTH      = 16,
  parameter int WEIGHT_FRAC_BITS = 16,
  localparam int W      = COORD_WIDTH,
  localparam int F      = WEIGHT_FRAC_BITS,
  localparam int E      = W + 1,
  localparam int SIDE_W = 3 * (W + 2 * E)
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  cpt_pkg::cpt_ctrl_t           in_ctrl,
  input  wire [F:0]                    in_q [2],
  input  wire [1:0]                    in_cls [2],
  input  wire [SIDE_W-1:0]             in_side,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [cpt_pkg::FIELD_W-1:0]  out_near [3],
  output logic [2:0]                   out_region,
  output logic                         out_degen
);

  localparam int N  = 3;
  localparam int MW = E + F + 2;
  localparam int SW = W + F + 3;
  localparam logic [F:0]          WONE   = {1'b1, {F{1'b0}}};
  localparam logic signed [SW-1:0] HALF  = SW'({1'b1, {(F-1){1'b0}}});
  localparam logic signed [W+2:0] SAT_HI = {4'b0000, {(W-1){1'b1}}};
  localparam logic signed [W+2:0] SAT_LO = {4'b1111, {(W-1){1'b0}}};

  logic [N-1:0] v_r;
  logic [N:0]   rdy;
  logic [N-1:0] vin;

  always_comb begin
    rdy[N] = out_ready;
    for (int s = N - 1; s >= 0; s--) rdy[s] = !v_r[s] || rdy[s+1];
  end

  assign vin = {v_r[N-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < N; s++) if (rdy[s]) v_r[s] <= vin[s];
    end
  end

  // round each quotient, then form the complement weights
  logic [F:0]   w [2];
  logic [F+1:0] qp [2];
  logic [F:0]   s_nxt, t_nxt;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      qp[l] = {1'b0, in_q[l]} + (F+2)'(1);
      case (in_cls[l])
        cpt_pkg::CLS_ONE: w[l] = WONE;
        cpt_pkg::CLS_DIV: w[l] = (qp[l][F+1:1] > WONE) ? WONE : qp[l][F+1:1];
        default:          w[l] = '0;
      endcase
    end
    s_nxt = in_ctrl.s_comp ? WONE - w[cpt_pkg::LANE_T] : w[cpt_pkg::LANE_S];
    t_nxt = in_ctrl.t_comp ? WONE - w[cpt_pkg::LANE_S] : w[cpt_pkg::LANE_T];
  end

  logic [F:0]               s_r, t_r;
  cpt_pkg::cpt_ctrl_t       ctrl0_r;
  logic [SIDE_W-1:0]        side0_r;
  logic signed [W-1:0]      p0 [3];
  logic signed [E-1:0]      e0 [3], e1 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p0[i] = side0_r[i*(W+2*E) +: W];
      e0[i] = side0_r[i*(W+2*E)+W +: E];
      e1[i] = side0_r[i*(W+2*E)+W+E +: E];
    end
  end

  logic signed [W+F-1:0]    base_r [3];
  logic signed [MW-1:0]     m0_r [3], m1_r [3];
  logic [2:0]               region1_r, region2_r;
  logic                     degen1_r, degen2_r;
  logic [cpt_pkg::FIELD_W-1:0] near_r [3];

  // sum, floor shift and saturate
  logic signed [SW-1:0]     acc [3];
  logic signed [W+2:0]      qv [3];
  logic signed [W-1:0]      sat [3];
  logic signed [W+15:0]     ext [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = SW'(base_r[i]) + SW'(m0_r[i]) + SW'(m1_r[i]) + HALF;
      qv[i]  = acc[i][SW-1:F];
      if (qv[i] > SAT_HI)      sat[i] = SAT_HI[W-1:0];
      else if (qv[i] < SAT_LO) sat[i] = SAT_LO[W-1:0];
      else                     sat[i] = qv[i][W-1:0];
      ext[i] = (W+16)'(sat[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s_r     <= s_nxt;
      t_r     <= t_nxt;
      ctrl0_r <= in_ctrl;
      side0_r <= in_side;
    end
    if (rdy[1]) begin
      for (int i = 0; i < 3; i++) begin
        base_r[i] <= (W+F)'(p0[i]) <<< F;
        m0_r[i]   <= MW'(e0[i]) * MW'(signed'({1'b0, s_r}));
        m1_r[i]   <= MW'(e1[i]) * MW'(signed'({1'b0, t_r}));
      end
      region1_r <= ctrl0_r.region;
      degen1_r  <= ctrl0_r.degen;
    end
    if (rdy[2]) begin
      for (int i = 0; i < 3; i++) near_r[i] <= ext[i][15:0];
      region2_r <= region1_r;
      degen2_r  <= degen1_r;
    end
  end

  assign in_ready   = rdy[0];
  assign out_valid  = v_r[N-1];
  assign out_near   = near_r;
  assign out_region = region2_r;
  assign out_degen  = degen2_r;

  `CPT_ASSERT_IMP(a_edge_s0_weight, clk, rst_n, v_r[0] && ctrl0_r.region == cpt_pkg::REG_EDGE_S0, s_r == '0)
  `CPT_ASSERT_IMP(a_edge_t0_weight, clk, rst_n, v_r[0] && ctrl0_r.region == cpt_pkg::REG_EDGE_T0, t_r == '0)
  `CPT_ASSERT_IMP(a_edge_st_sum, clk, rst_n, v_r[0] && ctrl0_r.region == cpt_pkg::REG_EDGE_ST, ((F+2)'(s_r) + (F+2)'(t_r)) == (F+2)'(WONE))
  `CPT_ASSERT_NXT(a_blend_advance, clk, rst_n, v_r[1] && rdy[2], v_r[2])

endmodule

`default_nettype wire

>>> src/closest_point_on_triangle.sv
// Top level of the closest-point-on-triangle block.
// Depends on cpt_pkg, cpt_setup, cpt_div and cpt_blend.
//
// Usage:
//   Input channel (in_*): one beat carries the three triangle corners and the
//   query point as twelve signed fixed-point coordinates. A beat is taken on
//   a rising edge with in_tvalid and in_tready both high.
//   Output channel (out_*): one beat per input beat, in order: the nearest
//   point on the triangle, the region code and the degenerate flag.
//   Throughput: one beat per cycle while the sink takes. Every stage has
//   its own valid bit and takes a new beat whenever it is empty or its
//   successor moves, so bubbles close up and a full pipeline keeps moving.
//   Depth: WEIGHT_FRAC_BITS + 11 register stages (27 at the defaults): six
//   setup stages, a divider classify stage plus one stage per quotient bit,
//   and three blend stages.
//   Reset: rst_n low on a clock edge empties every stage; no beat is
//   presented afterwards until new input arrives.
//   Stall: with out_tready low the last stage holds its beat, and the stages
//   behind it fill up before in_tready falls; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module closest_point_on_triangle #(
  parameter int COORD_WIDTH      = 16,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  // corner0_x, corner0_y, corner0_z, corner1_x, corner1_y, corner1_z,
  // corner2_x, corner2_y, corner2_z, query_x, query_y, query_z (16 bits each)
  input  wire  [cpt_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  // near_x, near_y, near_z (16 bits each)
  output logic [cpt_pkg::OUT_DATA_W-1:0]  out_tdata,
  // region (3 bits), degenerate (1 bit)
  output logic [cpt_pkg::OUT_USER_W-1:0]  out_tuser
);

  localparam int W      = COORD_WIDTH;
  localparam int F      = WEIGHT_FRAC_BITS;
  localparam int E      = W + 1;
  localparam int DW     = 4 * E + 6;
  localparam int SIDE_W = 3 * (W + 2 * E);

  // setup to divider
  logic                  sd_valid, sd_ready;
  cpt_pkg::cpt_ctrl_t    sd_ctrl;
  logic signed [DW-1:0]  sd_num [2];
  logic signed [DW-1:0]  sd_den [2];
  logic [SIDE_W-1:0]     sd_side;

  // divider to blend
  logic                  db_valid, db_ready;
  cpt_pkg::cpt_ctrl_t    db_ctrl;
  logic [F:0]            db_q [2];
  logic [1:0]            db_cls [2];
  logic [SIDE_W-1:0]     db_side;

  logic [cpt_pkg::FIELD_W-1:0] near [3];
  logic [2:0]                  region;
  logic                        degen;

  cpt_setup #(.COORD_WIDTH(COORD_WIDTH)) u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_tdata),
    .out_valid (sd_valid),
    .out_ready (sd_ready),
    .out_ctrl  (sd_ctrl),
    .out_num   (sd_num),
    .out_den   (sd_den),
    .out_side  (sd_side)
  );

  cpt_div #(
    .COORD_WIDTH      (COORD_WIDTH),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sd_valid),
    .in_ready  (sd_ready),
    .in_ctrl   (sd_ctrl),
    .in_num    (sd_num),
    .in_den    (sd_den),
    .in_side   (sd_side),
    .out_valid (db_valid),
    .out_ready (db_ready),
    .out_ctrl  (db_ctrl),
    .out_q     (db_q),
    .out_cls   (db_cls),
    .out_side  (db_side)
  );

  cpt_blend #(
    .COORD_WIDTH      (COORD_WIDTH),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_blend (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (db_valid),
    .in_ready   (db_ready),
    .in_ctrl    (db_ctrl),
    .in_q       (db_q),
    .in_cls     (db_cls),
    .in_side    (db_side),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_near   (near),
    .out_region (region),
    .out_degen  (degen)
  );

  // pack the result beat, lowest field first
  assign out_tdata = {near[2], near[1], near[0]};
  assign out_tuser = {degen, region};

endmodule

`default_nettype wire

>>> tb/closest_point_on_triangle_tb.sv
// Self-checking testbench for the closest-point-on-triangle block.
// Depends on cpt_pkg and the closest_point_on_triangle RTL; predicts every
// result in exact wide integers and compares each output beat field by field.
`timescale 1ns / 1ps
`default_nettype none

module closest_point_on_triangle_tb;

  // Wide enough for every product of the region sort without wrapping.
  typedef logic signed [191:0] wide_t;

  typedef struct packed {
    logic [15:0] near_x;
    logic [15:0] near_y;
    logic [15:0] near_z;
    logic [2:0]  region;
    logic        degen;
  } nearest_t;

  localparam longint WEIGHT_ONE = 64'sd65536;
  localparam int     CYCLE_LIMIT = 400000;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [cpt_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [cpt_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [cpt_pkg::OUT_USER_W-1:0] out_tuser;

  logic [cpt_pkg::IN_DATA_W-1:0] pending_queries[$];
  nearest_t             nearest_due[$];
  int                   error_count;
  int                   cycle_count;
  int                   hold_left;
  int                   gap_left;
  int                   burst_left;
  bit                   hold_done;

  closest_point_on_triangle DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Clamped weight num/den in Q1.16, rounded half up; a zero divisor flags.
  function automatic logic [16:0] clamp_weight(wide_t num, wide_t den, inout logic degen);
    wide_t       rem;
    logic [17:0] q;
    rem = num;
    q = '0;
    if (den == 0) begin
      degen = 1'b1;
      return '0;
    end
    if (num <= 0) return '0;
    if (!(num < den)) return 17'd65536;
    for (int i = 0; i <= 16; i++) begin
      rem = rem <<< 1;
      q = q << 1;
      if (!(rem < den)) begin
        rem = rem - den;
        q[0] = 1'b1;
      end
    end
    q = (q + 18'd1) >> 1;
    return (q > 18'd65536) ? 17'd65536 : q[16:0];
  endfunction

  // corner0 + edge0*s + edge1*t, rounded half up and saturated to 16 bits.
  function automatic logic [15:0] blend_coord(longint base, longint ed0, longint ed1,
                                              logic [16:0] s, logic [16:0] t);
    longint v;
    v = base * WEIGHT_ONE + ed0 * longint'(s) + ed1 * longint'(t) + 64'sd32768;
    v = v >>> 16;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic nearest_t predict_nearest(logic [cpt_pkg::IN_DATA_W-1:0] beat);
    longint      p0[3], e0[3], e1[3], v0[3];
    wide_t       a, b, c, dd, ee, det, sn, tn, den2, t0, t1;
    logic [16:0] s, t;
    logic [2:0]  rg;
    logic        degen;
    logic [15:0] nc[3];
    nearest_t    res;
    s = '0;
    t = '0;
    degen = 1'b0;
    for (int i = 0; i < 3; i++) begin
      p0[i] = longint'($signed(beat[i*16 +: 16]));
      e0[i] = longint'($signed(beat[(3+i)*16 +: 16])) - p0[i];
      e1[i] = longint'($signed(beat[(6+i)*16 +: 16])) - p0[i];
      v0[i] = p0[i] - longint'($signed(beat[(9+i)*16 +: 16]));
    end
    a = 0; b = 0; c = 0; dd = 0; ee = 0;
    for (int i = 0; i < 3; i++) begin
      a  = a  + wide_t'(e0[i]) * wide_t'(e0[i]);
      b  = b  + wide_t'(e0[i]) * wide_t'(e1[i]);
      c  = c  + wide_t'(e1[i]) * wide_t'(e1[i]);
      dd = dd + wide_t'(e0[i]) * wide_t'(v0[i]);
      ee = ee + wide_t'(e1[i]) * wide_t'(v0[i]);
    end
    det  = a * c - b * b;
    sn   = b * ee - c * dd;
    tn   = b * dd - a * ee;
    den2 = a - (b + b) + c;
    if (sn + tn < det) begin
      if (sn < 0) begin
        if (tn < 0) begin
          rg = cpt_pkg::REG_VERT_0;
          if (dd < 0) s = clamp_weight(-dd, a, degen);
          else t = clamp_weight(-ee, c, degen);
        end else begin
          rg = cpt_pkg::REG_EDGE_S0;
          t = clamp_weight(-ee, c, degen);
        end
      end else if (tn < 0) begin
        rg = cpt_pkg::REG_EDGE_T0;
        s = clamp_weight(-dd, a, degen);
      end else begin
        rg = cpt_pkg::REG_INTERIOR;
        s = clamp_weight(sn, det, degen);
        t = clamp_weight(tn, det, degen);
      end
    end else if (sn < 0) begin
      rg = cpt_pkg::REG_VERT_S;
      t0 = b + dd;
      t1 = c + ee;
      if (t0 < t1) begin
        s = clamp_weight(t1 - t0, den2, degen);
        t = 17'd65536 - s;
      end else t = clamp_weight(-ee, c, degen);
    end else if (tn < 0) begin
      rg = cpt_pkg::REG_VERT_T;
      t0 = b + ee;
      t1 = a + dd;
      if (t0 < t1) begin
        t = clamp_weight(t1 - t0, den2, degen);
        s = 17'd65536 - t;
      end else s = clamp_weight(-dd, a, degen);
    end else begin
      rg = cpt_pkg::REG_EDGE_ST;
      s = clamp_weight((c + ee) - (b + dd), den2, degen);
      t = 17'd65536 - s;
    end
    for (int i = 0; i < 3; i++) nc[i] = blend_coord(p0[i], e0[i], e1[i], s, t);
    res.near_x = nc[0];
    res.near_y = nc[1];
    res.near_z = nc[2];
    res.region = rg;
    res.degen  = degen;
    return res;
  endfunction

  // Corners in the low fields, query in the top three.
  function automatic logic [cpt_pkg::IN_DATA_W-1:0] pack_query(
      int c0x, int c0y, int c0z, int c1x, int c1y, int c1z,
      int c2x, int c2y, int c2z, int qx, int qy, int qz);
    return {qz[15:0], qy[15:0], qx[15:0], c2z[15:0], c2y[15:0], c2x[15:0],
            c1z[15:0], c1y[15:0], c1x[15:0], c0z[15:0], c0y[15:0], c0x[15:0]};
  endfunction

  function automatic int near_value(int centre, int spread);
    int v;
    v = centre + $signed($urandom_range(2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  // Driver: bursts of random length, random gaps; advance on each taken beat.
  always @(posedge clk) begin
    logic                          next_valid;
    logic [cpt_pkg::IN_DATA_W-1:0] next_data;
    next_valid = in_tvalid;
    next_data  = in_tdata;
    if (!rst_n) begin
      next_valid = 1'b0;
      gap_left   = 0;
      burst_left = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        nearest_due.push_back(predict_nearest(in_tdata));
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_queries.size() > 0) begin
          next_data  = pending_queries.pop_front();
          next_valid = 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(40, 1);
          end
          burst_left--;
          // Most bursts end in a gap; some run straight into the next.
          if (burst_left == 0 && $urandom_range(3) != 0) gap_left = $urandom_range(6, 1);
        end
      end
    end
    in_tvalid <= next_valid;
    in_tdata  <= next_data;
  end

  // Receiver: its own stall pattern, plus one long hold-off to fill the pipe.
  always @(posedge clk) begin
    logic ready_next;
    if (!rst_n) begin
      ready_next = 1'b0;
      hold_left  = 0;
      hold_done  = 1'b0;
    end else begin
      if (!hold_done && cycle_count > 400) begin
        hold_left = 300;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if ((cycle_count / 500) % 3 == 0) begin
        ready_next = 1'b1;  // stretch with no stalls
      end else begin
        ready_next = ($urandom_range(3) != 0);
      end
    end
    out_tready <= ready_next;
  end

  // Monitor: compare each taken beat with the oldest prediction.
  always @(posedge clk) begin
    nearest_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (nearest_due.size() == 0) begin
        $error("result beat with no prediction waiting");
        error_count++;
      end else begin
        want = nearest_due.pop_front();
        if (out_tdata[15:0] !== want.near_x) begin
          $error("near_x: expected %h, got %h", want.near_x, out_tdata[15:0]);
          error_count++;
        end
        if (out_tdata[31:16] !== want.near_y) begin
          $error("near_y: expected %h, got %h", want.near_y, out_tdata[31:16]);
          error_count++;
        end
        if (out_tdata[47:32] !== want.near_z) begin
          $error("near_z: expected %h, got %h", want.near_z, out_tdata[47:32]);
          error_count++;
        end
        if (out_tuser[2:0] !== want.region) begin
          $error("region: expected %0d, got %0d", want.region, out_tuser[2:0]);
          error_count++;
        end
        if (out_tuser[3] !== want.degen) begin
          $error("degenerate: expected %b, got %b", want.degen, out_tuser[3]);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int c[9];
    int cx, cy, cz, spread;
    error_count = 0;
    cycle_count = 0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    rst_n       = 1'b0;

    // Directed beats: extremes, every region, degenerate triangles.
    pending_queries.push_back('0);
    pending_queries.push_back('1);
    pending_queries.push_back({cpt_pkg::IN_FIELDS{16'h7fff}});
    pending_queries.push_back({cpt_pkg::IN_FIELDS{16'h8000}});
    pending_queries.push_back({{6{16'h8000}}, {6{16'h7fff}}});
    pending_queries.push_back(pack_query(0, 0, 0, 256, 0, 0, 0, 256, 0, 64, 64, 100));
    pending_queries.push_back(pack_query(0, 0, 0, 256, 0, 0, 0, 256, 0, 200, 200, 0));
    pending_queries.push_back(pack_query(0, 0, 0, 256, 0, 0, 0, 256, 0, -50, 100, 0));
    pending_queries.push_back(pack_query(0, 0, 0, 256, 0, 0, 0, 256, 0, 100, -50, 0));
    pending_queries.push_back(pack_query(0, 0, 0, 256, 0, 0, 0, 256, 0, -100, 400, 0));
    pending_queries.push_back(pack_query(0, 0, 0, 256, 0, 0, 0, 256, 0, -100, -100, 0));
    pending_queries.push_back(pack_query(0, 0, 0, 256, 0, 0, 0, 256, 0, 400, -100, 0));
    pending_queries.push_back(pack_query(0, 0, 0, 256, 0, 0, 0, 256, 0, 600, -10, 0));
    pending_queries.push_back(pack_query(0, 0, 0, 256, 0, 0, 0, 256, 0, -10, 600, 0));
    pending_queries.push_back(pack_query(0, 0, 0, 256, 0, 0, 0, 256, 0, 256, 0, 5));
    pending_queries.push_back(pack_query(0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 256, -5));
    pending_queries.push_back(pack_query(5, 5, 5, 5, 5, 5, 5, 5, 5, 100, -7, 3));
    pending_queries.push_back(pack_query(0, 0, 0, 100, 100, 100, 200, 200, 200, 50, 0, 9));
    pending_queries.push_back(pack_query(0, 0, 0, 0, 0, 0, 300, 1, 2, -40, 9, 9));
    pending_queries.push_back(pack_query(0, 0, 0, 300, 1, 2, 0, 0, 0, 400, 9, 9));
    pending_queries.push_back(pack_query(-32768, -32768, -32768, 32767, -32768, 0,
                                         -32768, 32767, 32767, 32767, 32767, -32768));
    pending_queries.push_back(pack_query(32767, 32767, 32767, -32768, 32767, 32767,
                                         32767, -32768, -32768, -32768, -32768, 32767));

    // Random beats: mostly queries near a triangle, some wholly random,
    // some degenerate triangles with shared corners or collinear edges.
    for (int n = 0; n < 1630; n++) begin
      case ($urandom_range(9))
        0, 1: pending_queries.push_back({$urandom, $urandom, $urandom,
                                         $urandom, $urandom, $urandom});
        2: begin
          cx = $signed($urandom_range(65535)) - 32768;
          cy = $signed($urandom_range(65535)) - 32768;
          cz = $signed($urandom_range(65535)) - 32768;
          c[0] = near_value(cx, 200); c[1] = near_value(cy, 200); c[2] = near_value(cz, 200);
          pending_queries.push_back(pack_query(cx, cy, cz, c[0], c[1], c[2],
                                               ($urandom_range(1) ? cx : c[0]),
                                               ($urandom_range(1) ? cy : c[1]),
                                               ($urandom_range(1) ? cz : c[2]),
                                               near_value(cx, 400), near_value(cy, 400),
                                               near_value(cz, 400)));
        end
        default: begin
          spread = $urandom_range(1) ? $urandom_range(64, 1) : $urandom_range(8000, 1);
          cx = $signed($urandom_range(65535)) - 32768;
          cy = $signed($urandom_range(65535)) - 32768;
          cz = $signed($urandom_range(65535)) - 32768;
          for (int k = 0; k < 6; k++) c[k] = near_value((k % 3 == 0) ? cx :
                                                          (k % 3 == 1) ? cy : cz, spread);
          pending_queries.push_back(pack_query(cx, cy, cz, c[0], c[1], c[2], c[3], c[4], c[5],
                                               near_value(cx, 2 * spread),
                                               near_value(cy, 2 * spread),
                                               near_value(cz, 2 * spread)));
        end
      endcase
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Hold until every beat has gone in and every prediction is met.
    wait (pending_queries.size() == 0 && !in_tvalid && nearest_due.size() == 0);
    repeat (60) @(posedge clk);
    if (error_count == 0 && nearest_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
